@@ hdl/dupd_pkg.sv @@
// ----------------------------------------------------------------------------
// dupd_pkg: shared types and helpers for the data URL payload decoder
// Character codes, register indexes, state structures and the small
// character classification and base64 step functions.
// ----------------------------------------------------------------------------
package dupd_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [0:0] REG_BASE64_MODE   = 1'b0;
  localparam logic [0:0] REG_PLUS_AS_SPACE = 1'b1;

  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_PCT  = 2'd1;
  localparam logic [1:0] HOLD_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] chr;
  } hold_t;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  pend;
    logic        pad;
  } b64_state_t;

  typedef struct packed {
    b64_state_t st;
    logic       emit;
    logic [7:0] data;
  } b64_out_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic            has;
    logic [2:0][7:0] bytes;
  } res_t;

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      d = 8'h10;
    end
    return d[4:0];
  endfunction

  // Bit 6 set means not a base64 character.
  function automatic logic [6:0] sextet_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else begin
      d = 8'd64;
    end
    return d[6:0];
  endfunction

  // One character through the second stage.
  function automatic b64_out_t b64_step(b64_state_t st, logic v, logic [7:0] c, logic mode);
    b64_out_t   r;
    logic [6:0] sx;
    logic [3:0] p;
    logic [11:0] sh;
    r.st   = st;
    r.emit = 1'b0;
    r.data = c;
    sx     = sextet_val(c);
    p      = st.pend + 4'd6;
    sh     = 12'h000;
    if (v) begin
      if (!mode) begin
        r.emit = 1'b1;
      end else if (!st.pad) begin
        if (c == CH_EQ) begin
          r.st.pad = 1'b1;
        end else if (!sx[6]) begin
          r.st.acc = {st.acc[5:0], sx[5:0]};
          if (p >= 4'd8) begin
            sh        = r.st.acc >> (p - 4'd8);
            r.emit    = 1'b1;
            r.data    = sh[7:0];
            r.st.pend = p - 4'd8;
          end else begin
            r.st.pend = p;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/dupd_decode.sv @@
// ----------------------------------------------------------------------------
// dupd_decode: next-state and result logic for one payload byte
// Percent-decodes the byte against the held escape, runs up to three
// resulting bytes through the base64 stage and packs the emitted bytes.
// ----------------------------------------------------------------------------
module dupd_decode (
  input  logic                 base64_mode,
  input  logic                 plus_as_space,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  dupd_pkg::hold_t      hold_i,
  input  dupd_pkg::b64_state_t b64_i,
  output dupd_pkg::hold_t      hold_o,
  output dupd_pkg::b64_state_t b64_o,
  output dupd_pkg::res_t       res_o
);

  logic [2:0]           seq_v;
  logic [2:0][7:0]      seq_b;
  logic [1:0]           n;
  dupd_pkg::hold_t      hold_mid;
  dupd_pkg::b64_out_t   s0, s1, s2;
  logic [2:0]           em;
  logic [2:0][7:0]      eb;
  logic [1:0]           k;
  logic [4:0]           hx_hi, hx_lo;
  logic [7:0]           lit_held, lit_in, lit_mid;

  always_comb begin
    hx_hi    = dupd_pkg::hex_val(hold_i.chr);
    hx_lo    = dupd_pkg::hex_val(in_byte);
    lit_held = (plus_as_space && hold_i.chr == dupd_pkg::CH_PLUS) ? dupd_pkg::CH_SPACE
                                                                  : hold_i.chr;
    lit_in   = (plus_as_space && in_byte == dupd_pkg::CH_PLUS) ? dupd_pkg::CH_SPACE : in_byte;
    seq_v    = 3'b000;
    seq_b    = '0;
    n        = 2'd0;
    hold_mid = hold_i;
    lit_mid  = 8'h00;

    case (hold_i.cnt)
      dupd_pkg::HOLD_TWO: begin
        if (!hx_hi[4] && !hx_lo[4]) begin
          seq_b[n]     = {hx_hi[3:0], hx_lo[3:0]};
          seq_v[n]     = 1'b1;
          n            = n + 2'd1;
          hold_mid.cnt = dupd_pkg::HOLD_NONE;
        end else begin
          seq_b[n] = dupd_pkg::CH_PCT;
          seq_v[n] = 1'b1;
          n        = n + 2'd1;
          if (hold_i.chr == dupd_pkg::CH_PCT) begin
            hold_mid.cnt = dupd_pkg::HOLD_TWO;
            hold_mid.chr = in_byte;
          end else begin
            seq_b[n] = lit_held;
            seq_v[n] = 1'b1;
            n        = n + 2'd1;
            if (in_byte == dupd_pkg::CH_PCT) begin
              hold_mid.cnt = dupd_pkg::HOLD_PCT;
            end else begin
              seq_b[n]     = lit_in;
              seq_v[n]     = 1'b1;
              n            = n + 2'd1;
              hold_mid.cnt = dupd_pkg::HOLD_NONE;
            end
          end
        end
      end
      dupd_pkg::HOLD_PCT: begin
        hold_mid.cnt = dupd_pkg::HOLD_TWO;
        hold_mid.chr = in_byte;
      end
      default: begin
        if (in_byte == dupd_pkg::CH_PCT) begin
          hold_mid.cnt = dupd_pkg::HOLD_PCT;
        end else begin
          seq_b[n] = lit_in;
          seq_v[n] = 1'b1;
          n        = n + 2'd1;
        end
      end
    endcase

    // An escape still open at the end of the payload goes out literally.
    if (in_last) begin
      if (hold_mid.cnt != dupd_pkg::HOLD_NONE) begin
        seq_b[n] = dupd_pkg::CH_PCT;
        seq_v[n] = 1'b1;
        n        = n + 2'd1;
      end
      if (hold_mid.cnt == dupd_pkg::HOLD_TWO) begin
        lit_mid  = (plus_as_space && hold_mid.chr == dupd_pkg::CH_PLUS) ? dupd_pkg::CH_SPACE
                                                                        : hold_mid.chr;
        seq_b[n] = lit_mid;
        seq_v[n] = 1'b1;
      end
    end
  end

  always_comb begin
    s0 = dupd_pkg::b64_step(b64_i, seq_v[0], seq_b[0], base64_mode);
    s1 = dupd_pkg::b64_step(s0.st, seq_v[1], seq_b[1], base64_mode);
    s2 = dupd_pkg::b64_step(s1.st, seq_v[2], seq_b[2], base64_mode);
    em = {s2.emit, s1.emit, s0.emit};
    eb = {s2.data, s1.data, s0.data};

    res_o = '0;
    k     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (em[i]) begin
        res_o.bytes[k] = eb[i];
        k              = k + 2'd1;
      end
    end
    res_o.cnt = k;
    res_o.has = 1'b1;

    hold_o = hold_mid;
    b64_o  = s2.st;
    if (in_last) begin
      hold_o = '0;
      b64_o  = '0;
      if (k == 2'd0) begin
        res_o.cnt = 2'd1;
        res_o.has = 1'b0;
      end
    end
  end

endmodule

@@ hdl/data_url_payload_decoder_top.sv @@
// ----------------------------------------------------------------------------
// data_url_payload_decoder_top: streaming data URL payload decoder
// Percent-decodes a payload byte stream, optionally base64-decodes it.
//
// Input words carry one payload byte in in_tdata, with in_tlast on the final
// byte. Output words carry one decoded byte in out_tdata; out_tuser is 1 when
// the byte is real data and 0 for a bare end mark, and out_tlast closes the
// payload. Every final input byte yields at least one output word.
// Each accepted byte is decoded combinationally into a three-slot result
// register; its words appear on the output the following cycle. A byte that
// yields at most one word lets the next byte in every cycle that the receiver
// is ready. A byte that yields two or three words (a broken escape or an
// escape cut by the end of the payload) holds the input until the result
// register, draining one word per ready cycle, is down to its last word.
// The user writes the two settings through cfg_we, cfg_addr and cfg_wdata only
// while the stream is idle (not enforced here); they apply from the next byte.
// Reset, synchronous and active low, empties the result register, clears
// the escape and base64 state and restores the register defaults (base64
// off, plus as space on). A stalled receiver holds the current word and,
// once the result register cannot take a new byte, stalls the input.
// ----------------------------------------------------------------------------
module data_url_payload_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [0:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] has_byte
  output logic       out_tlast
);

  logic                 base64_mode_r;
  logic                 plus_as_space_r;
  dupd_pkg::hold_t      hold_r, hold_nxt;
  dupd_pkg::b64_state_t b64_r, b64_nxt;
  dupd_pkg::res_t       res_nxt;
  logic [2:0][7:0]      slot_r;
  logic [1:0]           rem_r;
  logic                 has_r;
  logic                 last_r;
  logic                 in_fire, out_fire;

  dupd_decode u_decode (
    .base64_mode   (base64_mode_r),
    .plus_as_space (plus_as_space_r),
    .in_byte       (in_tdata),
    .in_last       (in_tlast),
    .hold_i        (hold_r),
    .b64_i         (b64_r),
    .hold_o        (hold_nxt),
    .b64_o         (b64_nxt),
    .res_o         (res_nxt)
  );

  assign in_tready  = (rem_r == 2'd0) || (rem_r == 2'd1 && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (rem_r != 2'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = slot_r[0];
  assign out_tuser  = has_r;
  assign out_tlast  = last_r && (rem_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base64_mode_r   <= 1'b0;
      plus_as_space_r <= 1'b1;
      hold_r          <= '0;
      b64_r           <= '0;
      rem_r           <= 2'd0;
      has_r           <= 1'b0;
      last_r          <= 1'b0;
      slot_r          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          dupd_pkg::REG_BASE64_MODE:   base64_mode_r   <= cfg_wdata[0];
          dupd_pkg::REG_PLUS_AS_SPACE: plus_as_space_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        hold_r <= hold_nxt;
        b64_r  <= b64_nxt;
        slot_r <= res_nxt.bytes;
        rem_r  <= res_nxt.cnt;
        has_r  <= res_nxt.has;
        last_r <= in_tlast;
      end else if (out_fire) begin
        slot_r <= {8'h00, slot_r[2], slot_r[1]};
        rem_r  <= rem_r - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_bare_mark_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && rem_r == 2'd1)
    else $error("bare end mark not the final word");

  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> out_tvalid && last_r)
    else $error("final byte produced no output word");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> hold_r.cnt == dupd_pkg::HOLD_NONE && b64_r.pend == 4'd0
                           && !b64_r.pad)
    else $error("stream state not cleared after final byte");

  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r.cnt != 2'd3 && (b64_r.pend == 4'd0 || b64_r.pend == 4'd2
                           || b64_r.pend == 4'd4 || b64_r.pend == 4'd6))
    else $error("escape or base64 state out of range");
`endif

endmodule
